### src/crcwd_pkg.sv
// crcwd_pkg: constants, parse phase encoding, result record and the crc-16 byte step
// shared by the deframer modules. No dependencies.

package crcwd_pkg;

   localparam logic [31:0] FRAME_MAGIC = 32'h5146_4D45;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] MAX_LEN_RST = 16'd8000;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned CNT_W   = 15;
   localparam int unsigned NBYTE_W = 3;
   localparam int unsigned RSP_DATA_W = 72;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'b0001,
      PH_HEADER  = 4'b0010,
      PH_CRC     = 4'b0100,
      PH_PAYLOAD = 4'b1000
   } phase_type;

   typedef struct packed {
      logic             crc_good;
      logic             end_of_frame;
      logic [2:0]       valid_bytes;
      logic [31:0]      payload_word;
      logic [15:0]      frame_len;
      logic [7:0]       frame_seq;
      logic [7:0]       frame_type;
   } result_type;

   // one byte through crc-16/ccitt-false, msb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### src/crcwd_crc_unit.sv
// crcwd_crc_unit: crc-16/ccitt-false over 0..4 bytes of a word, lowest byte first.
// Depends on crcwd_pkg.

module crcwd_crc_unit (
   input  logic [15:0] crc_start,
   input  logic [31:0] data,
   input  logic [2:0]  count,
   output logic [15:0] crc_out
);
   import crcwd_pkg::*;

   logic [15:0] c1, c2, c3, c4;

   assign c1 = crc_byte(crc_start, data[7:0]);
   assign c2 = crc_byte(c1, data[15:8]);
   assign c3 = crc_byte(c2, data[23:16]);
   assign c4 = crc_byte(c3, data[31:24]);

   always_comb begin
      unique case (count)
         3'd1:    crc_out = c1;
         3'd2:    crc_out = c2;
         3'd3:    crc_out = c3;
         3'd4:    crc_out = c4;
         default: crc_out = crc_start;
      endcase
   end

endmodule

### src/crcwd_parser.sv
// crcwd_parser: frame parse state machine, header/payload crc and result forming.
// Depends on crcwd_pkg and crcwd_crc_unit.

module crcwd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [31:0]            word,
   input  logic [15:0]            max_len,
   output logic                   res_valid,
   output crcwd_pkg::result_type  res
);
   import crcwd_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [7:0]         type_ff, type_in;
   logic [7:0]         seq_ff, seq_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [15:0]        exp_ff, exp_in;
   logic [15:0]        crc_ff, crc_in;
   logic [CNT_W-1:0]   need_ff, need_in;
   logic [CNT_W-1:0]   seen_ff, seen_in;

   logic [15:0]        hdr_crc, pay_crc;
   logic [16:0]        len_plus3;
   logic [16:0]        base, remain;
   logic [2:0]         nvalid;
   logic [31:0]        byte_mask;
   logic [CNT_W-1:0]   seen_nx;
   logic               last;

   crcwd_crc_unit u_hdr_crc (
      .crc_start (CRC_INIT),
      .data      ({word[15:8], word[7:0], word[23:16], word[31:24]}),
      .count     (3'd4),
      .crc_out   (hdr_crc)
   );

   crcwd_crc_unit u_pay_crc (
      .crc_start (crc_ff),
      .data      (word),
      .count     (nvalid),
      .crc_out   (pay_crc)
   );

   assign len_plus3 = {1'b0, word[15:0]} + 17'd3;
   assign base      = {seen_ff, 2'b00};
   assign remain    = ({1'b0, len_ff} > base) ? ({1'b0, len_ff} - base) : 17'd0;
   assign nvalid    = (remain > 17'd4) ? 3'd4 : remain[2:0];
   assign seen_nx   = seen_ff + 1'b1;
   assign last      = seen_nx >= need_ff;

   always_comb begin
      case (nvalid)
         3'd1:    byte_mask = 32'h0000_00FF;
         3'd2:    byte_mask = 32'h0000_FFFF;
         3'd3:    byte_mask = 32'h00FF_FFFF;
         3'd4:    byte_mask = 32'hFFFF_FFFF;
         default: byte_mask = 32'h0000_0000;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      seq_in    = seq_ff;
      len_in    = len_ff;
      exp_in    = exp_ff;
      crc_in    = crc_ff;
      need_in   = need_ff;
      seen_in   = seen_ff;
      res_valid = 1'b0;
      res.frame_type   = type_ff;
      res.frame_seq    = seq_ff;
      res.frame_len    = len_ff;
      res.payload_word = 32'd0;
      res.valid_bytes  = 3'd0;
      res.end_of_frame = 1'b0;
      res.crc_good     = 1'b0;

      unique case (phase_ff)
         PH_HUNT: begin
            if (word == FRAME_MAGIC) begin
               phase_in = PH_HEADER;
            end
         end
         PH_HEADER: begin
            if (word[15:0] > max_len) begin
               phase_in = PH_HUNT;
               type_in  = 8'd0;
               seq_in   = 8'd0;
               len_in   = '0;
               exp_in   = 16'd0;
               crc_in   = CRC_INIT;
               need_in  = '0;
               seen_in  = '0;
            end else begin
               type_in  = word[31:24];
               seq_in   = word[23:16];
               len_in   = word[15:0];
               need_in  = len_plus3[16:2];
               seen_in  = '0;
               crc_in   = hdr_crc;
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            exp_in = word[15:0];
            if (need_ff == '0) begin
               res_valid        = 1'b1;
               res.end_of_frame = 1'b1;
               res.crc_good     = (crc_ff == word[15:0]);
               phase_in = PH_HUNT;
               type_in  = 8'd0;
               seq_in   = 8'd0;
               len_in   = '0;
               exp_in   = 16'd0;
               crc_in   = CRC_INIT;
               need_in  = '0;
               seen_in  = '0;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            res_valid        = 1'b1;
            res.payload_word = word & byte_mask;
            res.valid_bytes  = nvalid;
            res.end_of_frame = last;
            res.crc_good     = last && (pay_crc == exp_ff);
            crc_in  = pay_crc;
            seen_in = seen_nx;
            if (last) begin
               phase_in = PH_HUNT;
               type_in  = 8'd0;
               seq_in   = 8'd0;
               len_in   = '0;
               exp_in   = 16'd0;
               crc_in   = CRC_INIT;
               need_in  = '0;
               seen_in  = '0;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         type_ff  <= 8'd0;
         seq_ff   <= 8'd0;
         len_ff   <= '0;
         exp_ff   <= 16'd0;
         crc_ff   <= CRC_INIT;
         need_ff  <= '0;
         seen_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         seq_ff   <= seq_in;
         len_ff   <= len_in;
         exp_ff   <= exp_in;
         crc_ff   <= crc_in;
         need_ff  <= need_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

### src/crc16_word_frame_deframer_unit.sv
// crc16_word_frame_deframer_unit: top level of the word stream frame deframer.
// Depends on crcwd_pkg and crcwd_parser.
//
//   port group   dir   width  contents
//   req_*        in    32     tdata: rx_word [31:0]
//   rsp_*        out   72     tdata: frame_type, frame_seq, frame_len, payload_word,
//                             valid_bytes; tlast: end_of_frame; tuser: crc_good
//   csr_*        in    16     max_payload_len, write only
//
// one word per cycle sustained while the result side is not stalled; a result reaches the
// ports through the input register, then parse and crc logic into the result register.
// reset is synchronous; it empties both registers, returns to magic hunt and loads
// max_payload_len with 8000. a stalled result holds the pipe; the input register
// still takes a word while it is empty.

module crc16_word_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] rx_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [crcwd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [7:0] frame_type, [15:8] frame_seq, [31:16] frame_len,
   // [63:32] payload_word, [66:64] valid_bytes, [71:67] zero
   output logic        rsp_tlast,   // end_of_frame
   output logic        rsp_tuser,   // [0] crc_good
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import crcwd_pkg::*;

   logic             in_valid_ff;
   logic [31:0]      in_word_ff;
   logic [15:0]      max_len_ff;
   logic             rsp_valid_ff;
   result_type       rsp_ff;
   logic             adv;
   logic             step;
   logic             res_valid;
   result_type       res;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && adv;
   assign req_tready = !in_valid_ff || adv;

   crcwd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .word      (in_word_ff),
      .max_len   (max_len_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RST;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_word_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.valid_bytes, rsp_ff.payload_word, rsp_ff.frame_len,
                        rsp_ff.frame_seq, rsp_ff.frame_type};
   assign rsp_tlast  = rsp_ff.end_of_frame;
   assign rsp_tuser  = rsp_ff.crc_good;

endmodule

### src/crcwd_checker.sv
// crcwd_checker: port level checks on the deframer result stream, bound to the top.
// Depends on crc16_word_frame_deframer_unit.

module crcwd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)
         && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a word that is not the last of its frame is full and not flagged crc good
   a_mid_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[66:64] == 3'd4 && !rsp_tuser)
      else $error("mid frame word not full or flagged good");

   // unused payload bytes and the pad bits read zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:67] == 5'd0
         && (rsp_tdata[66:64] != 3'd0 || rsp_tdata[63:32] == 32'd0)
         && (rsp_tdata[66:64] != 3'd1 || rsp_tdata[63:40] == 24'd0)
         && (rsp_tdata[66:64] != 3'd2 || rsp_tdata[63:48] == 16'd0)
         && (rsp_tdata[66:64] != 3'd3 || rsp_tdata[63:56] == 8'd0))
      else $error("payload bytes beyond count not zero");

endmodule

bind crc16_word_frame_deframer_unit crcwd_checker u_crcwd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

### dv/tb.sv
// tb: self-checking bench for crc16_word_frame_deframer_unit, driving framed word
// streams with random stalls and checking every result against a built-in frame parser.
// Depends on crcwd_pkg and the deframer RTL.
`timescale 1ns / 100ps

module tb;
   import crcwd_pkg::*;

   localparam int STALL_LIMIT = 2000;   // cycles with no handshake at all
   localparam int PIPE_DEPTH  = 4;      // a result passes the input register, then the result register

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   crc16_word_frame_deframer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // parser state of the bench's own frame tracker
   phase_type   rx_phase = PH_HUNT;
   logic [7:0]  hdr_type_q = '0;
   logic [7:0]  hdr_seq_q = '0;
   logic [15:0] hdr_len_q = '0;
   logic [15:0] crc_rx = '0;
   logic [15:0] crc_run = CRC_INIT;
   logic [14:0] words_total = '0;
   logic [14:0] words_done = '0;
   logic [15:0] max_len_cfg = MAX_LEN_RST;

   result_type expected_results[$];

   int words_sent = 0;
   int frames_sent = 0;
   int frames_bad = 0;
   int frames_cut = 0;
   int results_checked = 0;
   int eof_good = 0;
   int errors = 0;
   int quiet_cycles = 0;

   function automatic logic [15:0] crc16_next_byte(input logic [15:0] crc,
                                                   input logic [7:0] data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ data[i];
         c = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic logic [15:0] header_crc(input logic [7:0] ty, input logic [7:0] sq,
                                              input logic [15:0] len);
      logic [15:0] c;
      c = crc16_next_byte(CRC_INIT, ty);
      c = crc16_next_byte(c, sq);
      c = crc16_next_byte(c, len[7:0]);
      return crc16_next_byte(c, len[15:8]);
   endfunction

   task automatic clear_parse();
      rx_phase    = PH_HUNT;
      hdr_type_q  = '0;
      hdr_seq_q   = '0;
      hdr_len_q   = '0;
      crc_rx      = '0;
      crc_run     = CRC_INIT;
      words_total = '0;
      words_done  = '0;
   endtask

   // advance the frame tracker by one accepted word, queue any result it yields
   task automatic track_word(input logic [31:0] w);
      result_type  r;
      logic [16:0] span;
      logic [16:0] remain;
      logic [2:0]  nvalid;
      logic        last;
      r = '0;
      case (rx_phase)
         PH_HUNT: begin
            if (w == FRAME_MAGIC) begin
               rx_phase = PH_HEADER;
            end
         end
         PH_HEADER: begin
            hdr_type_q = w[31:24];
            hdr_seq_q  = w[23:16];
            hdr_len_q  = w[15:0];
            if (w[15:0] > max_len_cfg) begin
               clear_parse();
            end else begin
               span        = ({1'b0, w[15:0]} + 17'd3) >> 2;
               words_total = span[14:0];
               words_done  = '0;
               crc_run     = header_crc(w[31:24], w[23:16], w[15:0]);
               rx_phase    = PH_CRC;
            end
         end
         PH_CRC: begin
            crc_rx = w[15:0];
            if (words_total == 0) begin
               r.frame_type   = hdr_type_q;
               r.frame_seq    = hdr_seq_q;
               r.frame_len    = hdr_len_q;
               r.end_of_frame = 1'b1;
               r.crc_good     = (crc_run == crc_rx);
               expected_results.push_back(r);
               clear_parse();
            end else begin
               rx_phase = PH_PAYLOAD;
            end
         end
         default: begin
            span   = {words_done, 2'b00};
            remain = (hdr_len_q > span) ? {1'b0, hdr_len_q} - span : 17'd0;
            nvalid = (remain > 4) ? 3'd4 : remain[2:0];
            for (int b = 0; b < 4; b++) begin
               if (b < nvalid) begin
                  r.payload_word[8*b +: 8] = w[8*b +: 8];
                  crc_run = crc16_next_byte(crc_run, w[8*b +: 8]);
               end
            end
            words_done = words_done + 15'd1;
            last = (words_done >= words_total);
            r.frame_type   = hdr_type_q;
            r.frame_seq    = hdr_seq_q;
            r.frame_len    = hdr_len_q;
            r.valid_bytes  = nvalid;
            r.end_of_frame = last;
            r.crc_good     = last && (crc_run == crc_rx);
            expected_results.push_back(r);
            if (last) begin
               clear_parse();
            end
         end
      endcase
   endtask

   task automatic send_word(input logic [31:0] w);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      track_word(w);
   endtask

   // sends magic, header, crc and payload; cut drops that many trailing payload words
   task automatic send_frame(input logic [7:0] ty, input logic [7:0] sq,
                             input logic [15:0] len, input bit bad_crc,
                             input bit use_pat, input logic [31:0] pat, input int cut);
      logic [7:0]  body[$];
      logic [15:0] crc;
      logic [31:0] w;
      int          nwords;
      int          k;
      int          b;
      crc = header_crc(ty, sq, len);
      for (k = 0; k < len; k++) begin
         body.push_back(use_pat ? pat[8*(k%4) +: 8] : 8'($urandom));
         crc = crc16_next_byte(crc, body[k]);
      end
      if (bad_crc) begin
         crc = crc ^ 16'($urandom_range(1, 65535));
      end
      nwords = (int'(len) + 3) / 4;
      send_word(FRAME_MAGIC);
      send_word({ty, sq, len});
      send_word({16'($urandom), crc});
      for (k = 0; k < nwords - cut; k++) begin
         w = use_pat ? pat : $urandom;
         for (b = 0; b < 4; b++) begin
            if (4*k + b < len) begin
               w[8*b +: 8] = body[4*k + b];
            end
         end
         send_word(w);
      end
      if (cut > 0) begin
         frames_cut++;
      end else begin
         frames_sent++;
         if (bad_crc) begin
            frames_bad++;
         end
      end
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // a header or crc word may still sit in the pipe with nothing expected from it
   task automatic wait_idle();
      wait_results_done();
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [15:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      max_len_cfg = value;
   endtask

   task automatic test_directed_frames();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_frame(8'h00, 8'h00, 16'd0, 1'b0, 1'b1, 32'h0, 0);
      send_frame(8'hFF, 8'hFF, 16'd0, 1'b1, 1'b1, 32'h0, 0);
      send_frame(8'hA5, 8'h01, 16'd5, 1'b0, 1'b1, 32'hFFFF_FFFF, 0);
      // magic as payload must pass through as data
      send_frame(8'h3C, 8'h7E, 16'd4, 1'b0, 1'b1, FRAME_MAGIC, 0);
      // oversized header, magic right after it
      send_word(FRAME_MAGIC);
      send_word({8'h12, 8'h34, 16'd8001});
      send_frame(8'h80, 8'h40, 16'd3, 1'b0, 1'b1, 32'h0, 0);
      // magic twice: the second one is read as an oversized header
      send_word(FRAME_MAGIC);
      send_word(FRAME_MAGIC);
      send_frame(8'h01, 8'hFE, 16'd2, 1'b1, 1'b0, 32'h0, 0);
   endtask

   task automatic test_length_limits();
      send_idle_pct  = 13;
      recv_stall_pct = 13;
      write_max_len(16'd0);
      send_frame(8'($urandom), 8'($urandom), 16'd0, 1'b0, 1'b0, 32'h0, 0);
      send_frame(8'($urandom), 8'($urandom), 16'd0, 1'b1, 1'b0, 32'h0, 0);
      send_word(FRAME_MAGIC);
      send_word({16'($urandom), 16'd1});
      send_word(FRAME_MAGIC);
      send_word({16'($urandom), 16'hFFFF});
      send_frame(8'($urandom), 8'($urandom), 16'd0, 1'b0, 1'b0, 32'h0, 0);
      write_max_len(16'd4);
      send_frame(8'($urandom), 8'($urandom), 16'd4, 1'b0, 1'b0, 32'h0, 0);
      send_word(FRAME_MAGIC);
      send_word({16'($urandom), 16'd5});
      send_frame(8'($urandom), 8'($urandom), 16'd4, 1'b1, 1'b0, 32'h0, 0);
      write_max_len(16'hFFFF);
      send_frame(8'($urandom), 8'($urandom), 16'd255, 1'b0, 1'b0, 32'h0, 0);
      send_frame(8'($urandom), 8'($urandom), 16'd173, 1'b1, 1'b0, 32'h0, 0);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input logic [15:0] max_len, input int n_words);
      int  stop_at;
      int  pause_at;
      int  lim;
      int  pick;
      int  len;
      int  cut;
      bit  paused;
      write_max_len(max_len);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      stop_at  = words_sent + n_words;
      pause_at = words_sent + n_words / 2;
      paused   = 1'b0;
      lim = (max_len < 24) ? int'(max_len) : 24;
      while (words_sent < stop_at) begin
         if (!paused && words_sent >= pause_at) begin
            wait_results_done();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            if ($urandom_range(9) == 0) begin
               len = $urandom_range(0, (max_len < 400) ? int'(max_len) : 400);
            end else begin
               len = $urandom_range(0, lim);
            end
            send_frame(8'($urandom), 8'($urandom), 16'(len), $urandom_range(3) == 0,
                       1'b0, 32'h0, 0);
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 3)) send_word($urandom);
         end else if (pick < 87 && max_len != 16'hFFFF) begin
            send_word(FRAME_MAGIC);
            send_word({16'($urandom), 16'($urandom_range(int'(max_len) + 1, 65535))});
         end else if (pick < 94 && lim >= 5) begin
            len = $urandom_range(5, lim);
            cut = $urandom_range(1, (len + 3) / 4 - 1);
            send_frame(8'($urandom), 8'($urandom), 16'(len), 1'b0, 1'b0, 32'h0, cut);
         end else begin
            // random word in the header slot
            send_word(FRAME_MAGIC);
            send_word($urandom);
         end
      end
   endtask

   task automatic log_mismatch(input string what, input result_type want,
                               input result_type got);
      errors++;
      if (errors <= 10) begin
         $display("mismatch (%s) at %0t", what, $realtime);
         $display("   want type %02h seq %02h len %04h data %08h nb %0d eof %0b good %0b",
                  want.frame_type, want.frame_seq, want.frame_len, want.payload_word,
                  want.valid_bytes, want.end_of_frame, want.crc_good);
         $display("   got type %02h seq %02h len %04h data %08h nb %0d eof %0b good %0b",
                  got.frame_type, got.frame_seq, got.frame_len, got.payload_word,
                  got.valid_bytes, got.end_of_frame, got.crc_good);
      end
   endtask

   // result channel: random backpressure
   always @(posedge clock) begin
      rsp_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.frame_type   = rsp_tdata[7:0];
         got.frame_seq    = rsp_tdata[15:8];
         got.frame_len    = rsp_tdata[31:16];
         got.payload_word = rsp_tdata[63:32];
         got.valid_bytes  = rsp_tdata[66:64];
         got.end_of_frame = rsp_tlast;
         got.crc_good     = rsp_tuser;
         results_checked++;
         if (expected_results.size() == 0) begin
            log_mismatch("no result pending", '0, got);
         end else begin
            want = expected_results.pop_front();
            if (want.end_of_frame && want.crc_good) begin
               eof_good++;
            end
            if (got.frame_type !== want.frame_type || got.frame_seq !== want.frame_seq ||
                got.frame_len !== want.frame_len || got.payload_word !== want.payload_word ||
                got.valid_bytes !== want.valid_bytes ||
                got.end_of_frame !== want.end_of_frame || got.crc_good !== want.crc_good) begin
               log_mismatch("field", want, got);
            end else if (rsp_tdata[71:67] !== 5'd0) begin
               log_mismatch("pad bits set", want, got);
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_results.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      clear_parse();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      test_length_limits();
      test_random_traffic(0, 0, 16'd64, 290);
      test_random_traffic(65, 0, 16'($urandom_range(8, 200)), 290);
      test_random_traffic(0, 65, 16'hFFFF, 290);
      test_random_traffic(13, 13, 16'($urandom_range(0, 40)), 290);
      wait_idle();
      repeat (PIPE_DEPTH) @(posedge clock);
      errors += expected_results.size();
      $display("sent %0d words: %0d whole frames (%0d with a bad crc), %0d cut short",
               words_sent, frames_sent, frames_bad, frames_cut);
      $display("checked %0d results, %0d frames passed crc, limits 0 to 65535 exercised",
               results_checked, eof_good);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### sim.f
src/crcwd_pkg.sv
src/crcwd_crc_unit.sv
src/crcwd_parser.sv
src/crc16_word_frame_deframer_unit.sv
src/crcwd_checker.sv
dv/tb.sv
